FILE: sv/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared types and status codes of the best-fit buffer pool.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  typedef enum logic [1:0] {
    OP_CLAIM = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_EXACT    = 3'd0,
    ST_BIGGER   = 3'd1,
    ST_CREATED  = 3'd2,
    ST_FAILED   = 3'd3,
    ST_FREED    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_FULL     = 3'd6,
    ST_CLEARED  = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CDEC,
    S_CSCAN,
    S_CLAST,
    S_CMOVE,
    S_FSCAN,
    S_FLAST,
    S_FMOVE,
    S_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;      // capture request, zero scan index
    logic    scan_rd;   // read entry at scan index
    logic    scan_chk;  // evaluate read data against request
    logic    last_rd;   // read last entry of table
    logic    c_move;    // claim: write claimed, swap free
    logic    c_miss;    // claim miss handling
    logic    f_move;    // free: write free, swap claimed
    logic    clear;     // empty both tables
    logic    set_res;   // latch result for simple outcomes
    status_t res_st;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic claimed_full;
    logic free_full;
    logic scan_end;     // index reached count
    logic exact_hit;    // exact match found in current check
    logic picked;       // a candidate or match exists
  } stat_t;

endpackage

FILE: sv/best_fit_buffer_pool.sv
// ----------------------------------------------------------------------------
// best_fit_buffer_pool
// Best-fit pool of reusable buffers with free and claimed tables.
// ----------------------------------------------------------------------------
// One operation at a time. A claim or free scans its table one entry per
// cycle through the registered read port of the table RAM, then, when it has
// found an entry to move, reads the last entry and does the swap-remove write.
// The result is held on the out_ port until taken; the next item is accepted
// in the cycle after that transfer.
module best_fit_buffer_pool #(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_byte_size,
  input  logic [31:0] in_handle,
  input  logic        in_alloc_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_out_handle,
  output logic [31:0] out_out_size,
  output logic [4:0]  out_discarded,
  output logic [4:0]  out_leftover_claimed
);

  bfbp_pkg::cmd_t  cmd;
  bfbp_pkg::stat_t st;

  // sequencer
  bfbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .cmd(cmd)
  );

  // tables and result
  bfbp_dpath #(.POOL_DEPTH(POOL_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_op(in_op), .in_byte_size(in_byte_size),
    .in_handle(in_handle), .in_alloc_ok(in_alloc_ok),
    .cmd(cmd), .st(st),
    .out_status(out_status), .out_out_handle(out_out_handle),
    .out_out_size(out_out_size), .out_discarded(out_discarded),
    .out_leftover_claimed(out_leftover_claimed)
  );

endmodule

FILE: sv/bfbp_ram.sv
// ----------------------------------------------------------------------------
// bfbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bfbp_ctrl.sv
// ----------------------------------------------------------------------------
// bfbp_ctrl
// Sequencer for claim, free and clear operations.
// ----------------------------------------------------------------------------
module bfbp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bfbp_pkg::stat_t  st,
  output bfbp_pkg::cmd_t   cmd
);

  bfbp_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfbp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfbp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bfbp_pkg::S_CDEC;
      end
      bfbp_pkg::S_CDEC: begin
        unique case (st.op)
          bfbp_pkg::OP_CLAIM: begin
            if (st.claimed_full) state_nxt = bfbp_pkg::S_OUT;
            else state_nxt = bfbp_pkg::S_CSCAN;
          end
          bfbp_pkg::OP_FREE:  state_nxt = bfbp_pkg::S_FSCAN;
          default:            state_nxt = bfbp_pkg::S_OUT;
        endcase
      end
      bfbp_pkg::S_CSCAN: begin
        if (st.exact_hit) state_nxt = bfbp_pkg::S_CLAST;
        else if (st.scan_end) begin
          if (st.picked) state_nxt = bfbp_pkg::S_CLAST;
          else state_nxt = bfbp_pkg::S_OUT;
        end
      end
      bfbp_pkg::S_CLAST: state_nxt = bfbp_pkg::S_CMOVE;
      bfbp_pkg::S_CMOVE: state_nxt = bfbp_pkg::S_OUT;
      bfbp_pkg::S_FSCAN: begin
        if (st.exact_hit) begin
          if (st.free_full) state_nxt = bfbp_pkg::S_OUT;
          else state_nxt = bfbp_pkg::S_FLAST;
        end else if (st.scan_end) state_nxt = bfbp_pkg::S_OUT;
      end
      bfbp_pkg::S_FLAST: state_nxt = bfbp_pkg::S_FMOVE;
      bfbp_pkg::S_FMOVE: state_nxt = bfbp_pkg::S_OUT;
      bfbp_pkg::S_OUT: begin
        if (out_ready) state_nxt = bfbp_pkg::S_IDLE;
      end
      default: state_nxt = bfbp_pkg::S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd = '0;
    cmd.res_st = bfbp_pkg::ST_NOTFOUND;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bfbp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bfbp_pkg::S_CDEC: begin
        unique case (st.op)
          bfbp_pkg::OP_CLAIM: begin
            if (st.claimed_full) begin
              cmd.set_res = 1'b1;
              cmd.res_st = bfbp_pkg::ST_FULL;
            end else cmd.scan_rd = 1'b1;
          end
          bfbp_pkg::OP_FREE: cmd.scan_rd = 1'b1;
          bfbp_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res_st = bfbp_pkg::ST_CLEARED;
          end
          default: begin
            cmd.set_res = 1'b1;
            cmd.res_st = bfbp_pkg::ST_NOTFOUND;
          end
        endcase
      end
      bfbp_pkg::S_CSCAN: begin
        cmd.scan_chk = 1'b1;
        cmd.scan_rd = 1'b1;
        if (st.scan_end && !st.picked) cmd.c_miss = 1'b1;
      end
      bfbp_pkg::S_CLAST: cmd.last_rd = 1'b1;
      bfbp_pkg::S_CMOVE: cmd.c_move = 1'b1;
      bfbp_pkg::S_FSCAN: begin
        cmd.scan_chk = 1'b1;
        cmd.scan_rd = 1'b1;
        if (st.exact_hit && st.free_full) begin
          cmd.set_res = 1'b1;
          cmd.res_st = bfbp_pkg::ST_FULL;
        end else if (!st.exact_hit && st.scan_end) begin
          cmd.set_res = 1'b1;
          cmd.res_st = bfbp_pkg::ST_NOTFOUND;
        end
      end
      bfbp_pkg::S_FLAST: cmd.last_rd = 1'b1;
      bfbp_pkg::S_FMOVE: cmd.f_move = 1'b1;
      bfbp_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: sv/bfbp_dpath.sv
// ----------------------------------------------------------------------------
// bfbp_dpath
// Free and claimed tables, scan index, best-fit tracking and result registers.
// ----------------------------------------------------------------------------
module bfbp_dpath #(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_op,
  input  logic [31:0]     in_byte_size,
  input  logic [31:0]     in_handle,
  input  logic            in_alloc_ok,
  input  bfbp_pkg::cmd_t  cmd,
  output bfbp_pkg::stat_t st,
  output logic [2:0]      out_status,
  output logic [31:0]     out_out_handle,
  output logic [31:0]     out_out_size,
  output logic [4:0]      out_discarded,
  output logic [4:0]      out_leftover_claimed
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int EW = 32 + HANDLE_BITS;

  // captured request
  bfbp_pkg::op_t            op_r;
  logic [31:0]              req_size_r;
  logic [HANDLE_BITS-1:0]   req_handle_r;
  logic                     ok_r;

  // counts and scan state
  logic [CW-1:0] free_cnt_r, claimed_cnt_r;
  logic [CW-1:0] idx_r, idx_nxt;   // next index to read
  logic [CW-1:0] chk_r;            // index of entry on read data
  logic [AW-1:0] pick_r;
  logic [31:0]   pick_size_r;
  logic [HANDLE_BITS-1:0] pick_handle_r;
  logic          picked_r, exact_r;

  // result registers
  logic [2:0]  res_st_r;
  logic [31:0] res_h_r, res_sz_r;
  logic [4:0]  res_disc_r, res_left_r;

  // table ports
  logic          f_we, c_we;
  logic [AW-1:0] f_waddr, c_waddr, f_raddr, c_raddr;
  logic [EW-1:0] f_wdata, c_wdata, f_rdata, c_rdata;

  bfbp_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_free (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  bfbp_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH)) u_claimed (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  logic [31:0]            rd_size;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   cur_cnt_end;
  logic                   is_claim;
  logic [CW-1:0]          last_idx;

  assign is_claim  = (op_r == bfbp_pkg::OP_CLAIM);
  assign rd_size   = is_claim ? f_rdata[EW-1 -: 32] : c_rdata[EW-1 -: 32];
  assign rd_handle = is_claim ? f_rdata[HANDLE_BITS-1:0] : c_rdata[HANDLE_BITS-1:0];
  assign last_idx  = is_claim ? free_cnt_r - CW'(1) : claimed_cnt_r - CW'(1);

  // scan check: read data belongs to chk_r when chk_r below count
  logic chk_valid, hit_exact, hit_bigger;
  assign chk_valid  = cmd.scan_chk && (chk_r < (is_claim ? free_cnt_r : claimed_cnt_r));
  assign hit_exact  = chk_valid && (rd_size == req_size_r) &&
                      (is_claim || rd_handle == req_handle_r);
  assign hit_bigger = chk_valid && is_claim && (rd_size > req_size_r) &&
                      (!picked_r || pick_size_r > rd_size);
  assign cur_cnt_end = !chk_valid;

  // status to controller
  always_comb begin
    st.op           = op_r;
    st.claimed_full = (claimed_cnt_r >= CW'(POOL_DEPTH));
    st.free_full    = (free_cnt_r >= CW'(POOL_DEPTH));
    st.scan_end     = cur_cnt_end;
    st.exact_hit    = hit_exact;
    st.picked       = picked_r;
  end

  // read addressing
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) idx_nxt = '0;
    else if (cmd.scan_rd) idx_nxt = idx_r + CW'(1);
  end

  always_comb begin
    f_raddr = idx_r[AW-1:0];
    c_raddr = idx_r[AW-1:0];
    if (cmd.last_rd) begin
      f_raddr = last_idx[AW-1:0];
      c_raddr = last_idx[AW-1:0];
    end
  end

  // table writes: move picked entry and back-fill its slot from the last one, or add a created entry
  always_comb begin
    f_we = 1'b0; c_we = 1'b0;
    f_waddr = pick_r; c_waddr = pick_r;
    f_wdata = f_rdata; c_wdata = c_rdata;
    if (cmd.c_move) begin
      f_we    = 1'b1;
      f_waddr = pick_r;
      f_wdata = f_rdata;
      c_we    = 1'b1;
      c_waddr = claimed_cnt_r[AW-1:0];
      c_wdata = {pick_size_r, pick_handle_r};
    end else if (cmd.f_move) begin
      c_we    = 1'b1;
      c_waddr = pick_r;
      c_wdata = c_rdata;
      f_we    = 1'b1;
      f_waddr = free_cnt_r[AW-1:0];
      f_wdata = {req_size_r, req_handle_r};
    end else if (cmd.c_miss && ok_r) begin
      c_we    = 1'b1;
      c_waddr = claimed_cnt_r[AW-1:0];
      c_wdata = {req_size_r, req_handle_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r    <= '0;
      claimed_cnt_r <= '0;
      picked_r      <= 1'b0;
      exact_r       <= 1'b0;
      op_r          <= bfbp_pkg::OP_NONE;
    end else begin
      if (cmd.load) begin
        op_r     <= bfbp_pkg::op_t'(in_op);
        picked_r <= 1'b0;
        exact_r  <= 1'b0;
      end else if (hit_exact) begin
        picked_r <= 1'b1;
        exact_r  <= 1'b1;
      end else if (hit_bigger) begin
        picked_r <= 1'b1;
      end
      if (cmd.clear) begin
        free_cnt_r    <= '0;
        claimed_cnt_r <= '0;
      end else if (cmd.c_move) begin
        free_cnt_r    <= free_cnt_r - CW'(1);
        claimed_cnt_r <= claimed_cnt_r + CW'(1);
      end else if (cmd.f_move) begin
        free_cnt_r    <= free_cnt_r + CW'(1);
        claimed_cnt_r <= claimed_cnt_r - CW'(1);
      end else if (cmd.c_miss) begin
        free_cnt_r <= '0;
        if (ok_r) claimed_cnt_r <= claimed_cnt_r + CW'(1);
      end
    end
  end

  // payload registers: request, scan, pick and result
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    chk_r <= idx_r;
    if (cmd.load) begin
      req_size_r   <= in_byte_size;
      req_handle_r <= HANDLE_BITS'(in_handle);
      ok_r         <= in_alloc_ok;
    end
    if (hit_exact || hit_bigger) begin
      pick_r        <= chk_r[AW-1:0];
      pick_size_r   <= rd_size;
      pick_handle_r <= rd_handle;
    end
    if (cmd.set_res) begin
      res_st_r   <= cmd.res_st;
      res_h_r    <= '0;
      res_sz_r   <= '0;
      res_disc_r <= cmd.clear ? 5'(free_cnt_r) : 5'd0;
      res_left_r <= cmd.clear ? 5'(claimed_cnt_r) : 5'd0;
    end else if (cmd.c_move) begin
      res_st_r   <= exact_r ? bfbp_pkg::ST_EXACT : bfbp_pkg::ST_BIGGER;
      res_h_r    <= 32'(pick_handle_r[HW-1:0]);
      res_sz_r   <= pick_size_r;
      res_disc_r <= '0;
      res_left_r <= '0;
    end else if (cmd.f_move) begin
      res_st_r   <= bfbp_pkg::ST_FREED;
      res_h_r    <= 32'(req_handle_r[HW-1:0]);
      res_sz_r   <= req_size_r;
      res_disc_r <= '0;
      res_left_r <= '0;
    end else if (cmd.c_miss) begin
      res_st_r   <= ok_r ? bfbp_pkg::ST_CREATED : bfbp_pkg::ST_FAILED;
      res_h_r    <= ok_r ? 32'(req_handle_r[HW-1:0]) : 32'd0;
      res_sz_r   <= req_size_r;
      res_disc_r <= 5'(free_cnt_r);
      res_left_r <= '0;
    end
  end

  assign out_status           = res_st_r;
  assign out_out_handle       = res_h_r;
  assign out_out_size         = res_sz_r;
  assign out_discarded        = res_disc_r;
  assign out_leftover_claimed = res_left_r;

endmodule

FILE: test/best_fit_buffer_pool_tb.sv
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_tb
// Self-checking bench: directed and random claim/free/clear traffic against
// a behavioral model of the free and claimed tables, random stalls on both
// sides, and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool_tb;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hnd;
    logic [31:0] size;
    logic [4:0]  disc;
    logic [4:0]  left;
  } pool_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [31:0] in_byte_size;
  logic [31:0] in_handle;
  logic        in_alloc_ok;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_out_handle;
  logic [31:0] out_out_size;
  logic [4:0]  out_discarded;
  logic [4:0]  out_leftover_claimed;

  // model state of the two tables
  logic [31:0] free_sz [DEPTH];
  logic [31:0] free_hd [DEPTH];
  int          free_n;
  logic [31:0] held_sz [DEPTH];
  logic [31:0] held_hd [DEPTH];
  int          held_n;

  pool_result_t pending_results[$];
  int           mismatches;
  bit           rx_hold;
  int           next_handle;

  best_fit_buffer_pool u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_byte_size(in_byte_size),
    .in_handle(in_handle), .in_alloc_ok(in_alloc_ok),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_out_handle(out_out_handle),
    .out_out_size(out_out_size), .out_discarded(out_discarded),
    .out_leftover_claimed(out_leftover_claimed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pool behavior for one accepted operation
  function automatic pool_result_t predict_pool(bfbp_pkg::op_t op, logic [31:0] sz,
                                                logic [31:0] hd, logic ok);
    pool_result_t r;
    int pick;
    bit exact;
    bit bigger;
    int i;
    r = '0;
    r.status = bfbp_pkg::ST_NOTFOUND;
    pick = 0;
    exact = 0;
    bigger = 0;
    case (op)
      bfbp_pkg::OP_CLAIM: begin
        if (held_n >= DEPTH) begin
          r.status = bfbp_pkg::ST_FULL;
        end else begin
          for (i = 0; i < free_n; i++) begin
            if (free_sz[i] == sz) begin
              pick = i;
              exact = 1;
              break;
            end
            if (free_sz[i] > sz && (!bigger || free_sz[pick] > free_sz[i])) begin
              pick = i;
              bigger = 1;
            end
          end
          if (exact || bigger) begin
            r.status = exact ? bfbp_pkg::ST_EXACT : bfbp_pkg::ST_BIGGER;
            r.hnd = free_hd[pick];
            r.size = free_sz[pick];
            held_sz[held_n] = free_sz[pick];
            held_hd[held_n] = free_hd[pick];
            held_n++;
            free_sz[pick] = free_sz[free_n-1];
            free_hd[pick] = free_hd[free_n-1];
            free_n--;
          end else begin
            r.disc = 5'(free_n);
            r.size = sz;
            free_n = 0;
            if (ok) begin
              r.status = bfbp_pkg::ST_CREATED;
              r.hnd = hd;
              held_sz[held_n] = sz;
              held_hd[held_n] = hd;
              held_n++;
            end else begin
              r.status = bfbp_pkg::ST_FAILED;
            end
          end
        end
      end
      bfbp_pkg::OP_FREE: begin
        for (i = 0; i < held_n; i++) begin
          if (held_sz[i] == sz && held_hd[i] == hd) break;
        end
        if (i >= held_n) begin
          r.status = bfbp_pkg::ST_NOTFOUND;
        end else if (free_n >= DEPTH) begin
          r.status = bfbp_pkg::ST_FULL;
        end else begin
          held_sz[i] = held_sz[held_n-1];
          held_hd[i] = held_hd[held_n-1];
          held_n--;
          free_sz[free_n] = sz;
          free_hd[free_n] = hd;
          free_n++;
          r.status = bfbp_pkg::ST_FREED;
          r.hnd = hd;
          r.size = sz;
        end
      end
      bfbp_pkg::OP_CLEAR: begin
        r.status = bfbp_pkg::ST_CLEARED;
        r.disc = 5'(free_n);
        r.left = 5'(held_n);
        free_n = 0;
        held_n = 0;
      end
      default: r.status = bfbp_pkg::ST_NOTFOUND;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // send one operation, predicting at the transfer
  task automatic send_op(bfbp_pkg::op_t op, logic [31:0] sz, logic [31:0] hd, logic ok);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_byte_size <= sz;
    in_handle <= hd;
    in_alloc_ok <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_pool(op, sz, hd, ok));
  endtask

  // result checker
  always @(posedge clk) begin
    pool_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {29'd0, out_status}, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_status != w.status) report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_out_handle != w.hnd) report_mismatch("handle", out_out_handle, w.hnd);
        if (out_out_size != w.size) report_mismatch("size", out_out_size, w.size);
        if (out_discarded != w.disc) report_mismatch("discarded", 32'(out_discarded), 32'(w.disc));
        if (out_leftover_claimed != w.left)
          report_mismatch("leftover", 32'(out_leftover_claimed), 32'(w.left));
      end
    end
  end

  // receiver stalls, drawn per result
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(out_valid && out_ready) && !rx_hold) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // pick a size, often colliding with small values
  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8);
      1: return $urandom_range(0, 64);
      2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return rand_word();
    endcase
  endfunction

  task automatic test_directed();
    send_op(bfbp_pkg::OP_FREE, 32'd5, 32'd1, 1'b1);
    send_op(bfbp_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(bfbp_pkg::OP_CLAIM, 32'd0, 32'd0, 1'b0);
    send_op(bfbp_pkg::OP_CLAIM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(bfbp_pkg::OP_CLAIM, 32'd100, 32'h0000_00AA, 1'b1);
    send_op(bfbp_pkg::OP_CLAIM, 32'd50, 32'h0000_00BB, 1'b1);
    send_op(bfbp_pkg::OP_CLAIM, 32'd80, 32'h0000_00CC, 1'b1);
    send_op(bfbp_pkg::OP_FREE, 32'd100, 32'h0000_00AA, 1'b0);
    send_op(bfbp_pkg::OP_FREE, 32'd50, 32'h0000_00BB, 1'b0);
    send_op(bfbp_pkg::OP_FREE, 32'd80, 32'h0000_00CC, 1'b0);
    send_op(bfbp_pkg::OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_op(bfbp_pkg::OP_CLAIM, 32'd50, 32'd0, 1'b0);
    send_op(bfbp_pkg::OP_CLAIM, 32'd60, 32'd0, 1'b0);
    send_op(bfbp_pkg::OP_CLAIM, 32'd1000, 32'h5555_5555, 1'b0);
    send_op(bfbp_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b0);
    send_op(bfbp_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b0);
  endtask

  // fill the claimed table past its limit, then fill the free table
  task automatic test_full_tables();
    int i;
    for (i = 0; i < DEPTH + 2; i++)
      send_op(bfbp_pkg::OP_CLAIM, 32'(1000 + i), 32'(i + 1), 1'b1);
    for (i = 0; i < DEPTH; i++)
      send_op(bfbp_pkg::OP_FREE, 32'(1000 + i), 32'(i + 1), 1'b1);
    for (i = 0; i < DEPTH; i++)
      send_op(bfbp_pkg::OP_CLAIM, 32'd2000, 32'(i + 100), 1'b1);
    send_op(bfbp_pkg::OP_CLAIM, 32'd1, 32'd7, 1'b1);
    for (i = 0; i < DEPTH; i++)
      send_op(bfbp_pkg::OP_FREE, 32'd2000, 32'(i + 100), 1'b0);
    send_op(bfbp_pkg::OP_CLAIM, 32'd5, 32'd9, 1'b1);
    send_op(bfbp_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b0);
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    int i;
    rx_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 0;
      end
      for (i = 0; i < 12; i++) send_op(bfbp_pkg::op_t'($urandom_range(0, 3)), rand_size(),
                                       rand_word(), 1'($urandom()));
    join
  endtask

  // random mix, mostly claim/free pairs on tracked handles
  task automatic test_random(int n);
    int i;
    int k;
    logic [31:0] sz;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        sz = $urandom_range(0, 3) == 0 ? rand_size() : 32'($urandom_range(1, 40));
        next_handle++;
        send_op(bfbp_pkg::OP_CLAIM, sz,
                $urandom_range(0, 1) ? 32'(next_handle) : rand_word(),
                $urandom_range(0, 7) != 0);
      end else if (k < 85 && held_n > 0) begin
        sz = $urandom_range(0, held_n - 1);
        if ($urandom_range(0, 9) == 0)
          send_op(bfbp_pkg::OP_FREE, held_sz[sz] ^ 32'd1, held_hd[sz], 1'($urandom()));
        else
          send_op(bfbp_pkg::OP_FREE, held_sz[sz], held_hd[sz], 1'($urandom()));
      end else if (k < 90) begin
        send_op(bfbp_pkg::OP_CLEAR, rand_word(), rand_word(), 1'($urandom()));
      end else if (k < 93) begin
        send_op(bfbp_pkg::OP_NONE, rand_word(), rand_word(), 1'($urandom()));
      end else begin
        send_op(bfbp_pkg::OP_FREE, rand_size(), rand_word(), 1'($urandom()));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = bfbp_pkg::OP_CLAIM;
    in_byte_size = '0;
    in_handle = '0;
    in_alloc_ok = 1'b0;
    mismatches = 0;
    rx_hold = 0;
    free_n = 0;
    held_n = 0;
    next_handle = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_tables();
    test_backpressure();
    test_random(1450);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("best_fit_buffer_pool: match");
    end else begin
      $display("best_fit_buffer_pool: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #10000000;
    $display("best_fit_buffer_pool: mismatch");
    $finish;
  end

endmodule
